// ----- src/pchr_pkg.sv -----
// ============================================================================
// pchr_pkg
// Shared types, constants and helpers for the PCI type 0 configuration
// header block.
// ============================================================================
package pchr_pkg;

    // Number of implemented base address registers (1 to 6).
    localparam int NUM_BARS = 6;

    // Header image geometry, in dwords.
    localparam int HDR_DWORDS = 16;
    localparam int DW_AW      = $clog2(HDR_DWORDS);

    // Dword slots of the header image.
    localparam logic [DW_AW-1:0] DW_ID       = 4'd0;
    localparam logic [DW_AW-1:0] DW_CMD_STAT = 4'd1;
    localparam logic [DW_AW-1:0] DW_CACHE    = 4'd3;
    localparam logic [DW_AW-1:0] DW_BAR0     = 4'd4;
    localparam logic [DW_AW-1:0] DW_ROM      = 4'd12;
    localparam logic [DW_AW-1:0] DW_LAST     = 4'd15;
    localparam logic [DW_AW-1:0] DW_IRQ      = 4'd15;

    // Byte offsets of the writable registers.
    localparam logic [7:0] OFS_COMMAND  = 8'h04;
    localparam logic [7:0] OFS_STATUS   = 8'h06;
    localparam logic [7:0] OFS_CACHE    = 8'h0C;
    localparam logic [7:0] OFS_LATENCY  = 8'h0D;
    localparam logic [7:0] OFS_BAR0     = 8'h10;
    localparam logic [7:0] OFS_ROM      = 8'h30;
    localparam logic [7:0] OFS_IRQ_LINE = 8'h3C;

    // Access types and sizes.
    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;
    localparam logic [2:0] ACC_BYTE  = 3'd1;
    localparam logic [2:0] ACC_HALF  = 3'd2;
    localparam logic [2:0] ACC_DWORD = 3'd4;

    // Completion status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BEYOND    = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [1:0] ST_READ_ONLY = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BAR0_SIZE = 3'd0;
    localparam logic [2:0] CFG_IO_MASK   = 3'd6;
    localparam logic [2:0] CFG_VDID      = 3'd7;

    // BAR and ROM data constants.
    localparam logic [31:0] BAR_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] ROM_PROBE     = 32'hFFFF_FFFE;
    localparam logic [31:0] IO_TYPE_MASK  = 32'h0000_0003;
    localparam logic [31:0] MEM_TYPE_MASK = 32'h0000_000F;
    localparam logic [31:0] IO_TYPE_BITS  = 32'h0000_0001;
    localparam logic [31:0] MEM_ONLY_BITS = 32'h0000_000C;

    // Implemented bytes of partly used dwords.
    localparam logic [31:0] CACHE_DW_MASK = 32'h0000_FFFF;
    localparam logic [31:0] IRQ_DW_MASK   = 32'h0000_00FF;

    // Request and response payloads.
    typedef struct packed {
        logic        req_type;
        logic [7:0]  offset;
        logic [2:0]  access_size;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } rsp_t;

    // Configuration state seen by the datapath.
    typedef struct packed {
        logic [NUM_BARS-1:0][31:0] bar_size;
        logic [5:0]                io_mask;
        logic [31:0]               vendor_device_id;
        logic                      mask_wr;
        logic [5:0]                mask_new;
    } cfg_t;

    // Write-back request into the header image.
    typedef struct packed {
        logic             en;
        logic             bar;
        logic [DW_AW-1:0] addr;
        logic [31:0]      data;
    } img_wr_t;

    // Force the type bits of a BAR word.
    function automatic logic [31:0] bar_type_fix(input logic is_io, input logic [31:0] w);
        logic [31:0] r;
        if (is_io)
        begin
            r = (w & ~IO_TYPE_MASK) | IO_TYPE_BITS;
        end
        else
        begin
            r = w & ~MEM_TYPE_MASK;
        end
        return r;
    endfunction

endpackage

// ----- src/pchr_cfg.sv -----
// ============================================================================
// pchr_cfg
// Configuration register file: BAR sizes, BAR type mask and the identity
// dword, written through a plain write port.
// ============================================================================
module pchr_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output pchr_pkg::cfg_t cfg
);

    logic [pchr_pkg::NUM_BARS-1:0][31:0] bar_size_reg;
    logic [5:0]                          io_mask_reg;
    logic [31:0]                         vdid_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_size_reg <= '0;
            io_mask_reg  <= '0;
            vdid_reg     <= '0;
        end
        else if (cfg_we)
        begin
            for (int j = 0; j < pchr_pkg::NUM_BARS; j++)
            begin
                if (cfg_index == pchr_pkg::CFG_BAR0_SIZE + 3'(j))
                begin
                    bar_size_reg[j] <= cfg_data;
                end
            end
            if (cfg_index == pchr_pkg::CFG_IO_MASK)
            begin
                io_mask_reg <= cfg_data[5:0];
            end
            if (cfg_index == pchr_pkg::CFG_VDID)
            begin
                vdid_reg <= cfg_data;
            end
        end
    end

    // The mask write event goes out in the same cycle so the image can mark
    // every BAR for a type-bit update.
    always_comb
    begin
        cfg.bar_size         = bar_size_reg;
        cfg.io_mask          = io_mask_reg;
        cfg.vendor_device_id = vdid_reg;
        cfg.mask_wr          = cfg_we && (cfg_index == pchr_pkg::CFG_IO_MASK);
        cfg.mask_new         = cfg_data[5:0];
    end

endmodule

// ----- src/pchr_image.sv -----
// ============================================================================
// pchr_image
// Header image memory: sixteen dwords with a registered read port, per-dword
// valid bits, and the read view that adds the identity dword, masks
// unimplemented bytes and applies pending BAR type-bit updates.
// ============================================================================
module pchr_image (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pchr_pkg::cfg_t                 cfg,
    input  logic                           rd_en,
    input  logic [pchr_pkg::DW_AW-1:0]     rd_addr,
    input  pchr_pkg::img_wr_t              wr,
    output logic [31:0]                    view
);

    logic [31:0]                    mem [pchr_pkg::HDR_DWORDS];
    logic [31:0]                    rdata_reg;
    logic [pchr_pkg::DW_AW-1:0]     rd_addr_reg;
    logic                           rd_valid_reg;
    logic [pchr_pkg::HDR_DWORDS-1:0] valid_reg;
    // A BAR marked pending has seen a type mask write since it was stored;
    // clr marks that a memory-type pass has since wiped bits 3..2.
    logic [pchr_pkg::NUM_BARS-1:0]  pend_reg;
    logic [pchr_pkg::NUM_BARS-1:0]  clr_reg;
    logic [31:0]                    raw;
    logic [31:0]                    bar_w;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Read address and valid bit travel with the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_addr_reg  <= rd_addr;
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // Pending type-bit updates per BAR.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            for (int j = 0; j < pchr_pkg::NUM_BARS; j++)
            begin
                if (cfg.mask_wr)
                begin
                    pend_reg[j] <= 1'b1;
                    clr_reg[j]  <= clr_reg[j] | ~cfg.mask_new[j];
                end
                else if (wr.en && wr.bar && (wr.addr == pchr_pkg::DW_BAR0 + 4'(j)))
                begin
                    pend_reg[j] <= 1'b0;
                    clr_reg[j]  <= 1'b0;
                end
            end
        end
    end

    // Read view of the addressed dword.
    always_comb
    begin
        raw   = rd_valid_reg ? rdata_reg : '0;
        bar_w = '0;
        case (rd_addr_reg)
            pchr_pkg::DW_ID:       view = cfg.vendor_device_id;
            pchr_pkg::DW_CMD_STAT: view = raw;
            pchr_pkg::DW_CACHE:    view = raw & pchr_pkg::CACHE_DW_MASK;
            pchr_pkg::DW_ROM:      view = raw;
            pchr_pkg::DW_IRQ:      view = raw & pchr_pkg::IRQ_DW_MASK;
            default:               view = '0;
        endcase
        for (int j = 0; j < pchr_pkg::NUM_BARS; j++)
        begin
            if (rd_addr_reg == pchr_pkg::DW_BAR0 + 4'(j))
            begin
                bar_w = clr_reg[j] ? (raw & ~pchr_pkg::MEM_ONLY_BITS) : raw;
                view  = pend_reg[j] ? pchr_pkg::bar_type_fix(cfg.io_mask[j], bar_w) : raw;
            end
        end
    end

endmodule

// ----- src/pci_config_header_regs.sv -----
// ============================================================================
// pci_config_header_regs
// PCI type 0 configuration header: byte, halfword and dword accesses to the
// 64-byte header image, with BAR size probing and error status.
// ============================================================================
//
//  Channel  Signals                          Direction  Content
//  -------  -------------------------------  ---------  --------------------------
//  in       in_valid / in_ready / in_data    input      access request (req_t)
//  out      out_valid / out_ready / out_data output     read data and status (rsp_t)
//  cfg      cfg_we / cfg_index / cfg_data    input      config register write
//
// Each transaction steps from acceptance to a loaded result: accept with the
// first image read, the second image read of the next dword for every
// access, capture, then the write-back and result load. The header image
// memory has a single read port, so the two dwords are read one after another.
// A new request is accepted only when the previous one has finished; a
// result stalled on out_ready holds the block in its last step. No clearing
// pass is needed after reset: per-dword valid bits make the image read zero.
//
module pci_config_header_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pchr_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pchr_pkg::rsp_t out_data,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LO   = 2'd1;
    localparam logic [1:0] S_HI   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    pchr_pkg::cfg_t            cfg;
    pchr_pkg::img_wr_t         img_wr;
    pchr_pkg::req_t            req_reg;
    pchr_pkg::rsp_t            rsp;
    pchr_pkg::rsp_t            out_reg;
    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [31:0]               lo_reg;
    logic [31:0]               hi_reg;
    logic                      out_valid_reg;
    logic                      rd_en;
    logic [pchr_pkg::DW_AW-1:0] rd_addr;
    logic [31:0]               view;
    logic                      accept;
    logic                      fin_go;
    logic [63:0]               shifted;
    logic [31:0]               wd;
    logic [31:0]               new_w;
    logic                      wr_en;
    logic                      wr_bar;

    pchr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pchr_image u_image (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (img_wr),
        .view    (view)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Image read address: the first dword at acceptance, the next one after.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = in_data.offset[5:2];
        case (state_reg)
            S_IDLE:
            begin
                rd_en   = accept;
                rd_addr = in_data.offset[5:2];
            end
            S_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = req_reg.offset[5:2] + 4'd1;
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = req_reg.offset[5:2];
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_LO : S_IDLE;
            S_LO:    state_next = S_HI;
            S_HI:    state_next = S_FIN;
            S_FIN:   state_next = fin_go ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and image dwords; the dword past the header reads as zero.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
        if (state_reg == S_LO)
        begin
            lo_reg <= view;
        end
        if (state_reg == S_HI)
        begin
            hi_reg <= (req_reg.offset[5:2] == pchr_pkg::DW_LAST) ? '0 : view;
        end
        if (fin_go)
        begin
            out_reg <= rsp;
        end
    end

    // Result and write-back for the finished transaction.
    always_comb
    begin
        wd      = req_reg.write_data;
        shifted = {hi_reg, lo_reg} >> {req_reg.offset[1:0], 3'b000};
        rsp     = '0;
        new_w   = lo_reg;
        wr_en   = 1'b0;
        wr_bar  = 1'b0;
        if (req_reg.offset[7:6] != 2'b00)
        begin
            rsp.status = pchr_pkg::ST_BEYOND;
        end
        else if ((req_reg.access_size != pchr_pkg::ACC_BYTE) &&
                 (req_reg.access_size != pchr_pkg::ACC_HALF) &&
                 (req_reg.access_size != pchr_pkg::ACC_DWORD))
        begin
            rsp.status = pchr_pkg::ST_BAD_SIZE;
        end
        else if (req_reg.req_type == pchr_pkg::REQ_READ)
        begin
            case (req_reg.access_size)
                pchr_pkg::ACC_BYTE: rsp.read_data = {24'd0, shifted[7:0]};
                pchr_pkg::ACC_HALF: rsp.read_data = {16'd0, shifted[15:0]};
                default:            rsp.read_data = shifted[31:0];
            endcase
        end
        else
        begin
            case (req_reg.access_size)
                pchr_pkg::ACC_BYTE:
                begin
                    case (req_reg.offset)
                        pchr_pkg::OFS_CACHE:
                        begin
                            new_w = {lo_reg[31:8], wd[7:0]};
                            wr_en = 1'b1;
                        end
                        pchr_pkg::OFS_LATENCY:
                        begin
                            new_w = {lo_reg[31:16], wd[7:0], lo_reg[7:0]};
                            wr_en = 1'b1;
                        end
                        pchr_pkg::OFS_IRQ_LINE:
                        begin
                            new_w = {lo_reg[31:8], wd[7:0]};
                            wr_en = 1'b1;
                        end
                        default: rsp.status = pchr_pkg::ST_READ_ONLY;
                    endcase
                end
                pchr_pkg::ACC_HALF:
                begin
                    case (req_reg.offset)
                        pchr_pkg::OFS_COMMAND, pchr_pkg::OFS_CACHE:
                        begin
                            new_w = {lo_reg[31:16], wd[15:0]};
                            wr_en = 1'b1;
                        end
                        pchr_pkg::OFS_STATUS:
                        begin
                            new_w = {wd[15:0], lo_reg[15:0]};
                            wr_en = 1'b1;
                        end
                        default: rsp.status = pchr_pkg::ST_READ_ONLY;
                    endcase
                end
                default:
                begin
                    // Dword writes to read-only places are dropped quietly.
                    if (req_reg.offset == pchr_pkg::OFS_ROM)
                    begin
                        new_w = (wd == pchr_pkg::ROM_PROBE) ? pchr_pkg::BAR_ALL_ONES : wd;
                        wr_en = 1'b1;
                    end
                    else if (req_reg.offset == pchr_pkg::OFS_COMMAND)
                    begin
                        new_w = {lo_reg[31:16], wd[15:0]};
                        wr_en = 1'b1;
                    end
                    for (int j = 0; j < pchr_pkg::NUM_BARS; j++)
                    begin
                        if (req_reg.offset == pchr_pkg::OFS_BAR0 + 8'(4 * j))
                        begin
                            wr_en  = 1'b1;
                            wr_bar = 1'b1;
                            if (wd == pchr_pkg::BAR_ALL_ONES)
                            begin
                                // Size probe: negated size plus the I/O flag.
                                new_w = ~(cfg.bar_size[j] - 32'd1) |
                                        (cfg.io_mask[j] ? pchr_pkg::IO_TYPE_BITS : 32'd0);
                            end
                            else
                            begin
                                new_w = pchr_pkg::bar_type_fix(cfg.io_mask[j], wd);
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        img_wr.en   = fin_go && wr_en;
        img_wr.bar  = wr_bar;
        img_wr.addr = req_reg.offset[5:2];
        img_wr.data = new_w;
    end

endmodule

// ----- test/pchr_access_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// pchr_access_checker
// Watches the request, completion and configuration ports of the PCI
// configuration header block, keeps its own copy of the header image,
// predicts the completion of every accepted request and compares each
// accepted completion with the oldest prediction.
// ============================================================================
module pchr_access_checker
    import pchr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  req_t        in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  rsp_t        out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          error_count,
    output int          pending
);

    localparam int HEADER_BYTES = 64;
    localparam int PRINT_CAP    = 200;

    // A completion still owed by the block, with the request that caused it.
    typedef struct packed {
        req_t req;
        rsp_t rsp;
    } due_t;

    // Configuration copy.
    logic [31:0] size_reg [6];
    logic [5:0]  io_sel;
    logic [31:0] id_word;

    // Header image copy.
    logic [31:0] bar_img [NUM_BARS];
    logic [31:0] rom_img;
    logic [15:0] cmd_img;
    logic [15:0] stat_img;
    logic [7:0]  cls_img;
    logic [7:0]  lat_img;
    logic [7:0]  irq_img;

    due_t owed_completions [$];

    initial
    begin
        error_count = 0;
        pending     = 0;
    end

    // One line per mismatch; past the cap the failure is only counted.
    task automatic report_fail(input string msg);
        if (error_count < PRINT_CAP)
        begin
            $display("%0t ns  MISMATCH  %s", $time, msg);
        end
        error_count++;
    endtask

    // Force the type bits of BAR n according to the current I/O mask.
    function automatic logic [31:0] with_type_bits(input int unsigned n, input logic [31:0] w);
        logic [31:0] r;
        if (io_sel[n])
        begin
            r = (w & ~IO_TYPE_MASK) | IO_TYPE_BITS;
        end
        else
        begin
            r = w & ~MEM_TYPE_MASK;
        end
        return r;
    endfunction

    task automatic reset_image();
        int i;
        for (i = 0; i < 6; i++)
        begin
            size_reg[i] = '0;
        end
        io_sel  = '0;
        id_word = '0;
        for (i = 0; i < NUM_BARS; i++)
        begin
            bar_img[i] = io_sel[i] ? IO_TYPE_BITS : 32'h0;
        end
        rom_img  = '0;
        cmd_img  = '0;
        stat_img = '0;
        cls_img  = '0;
        lat_img  = '0;
        irq_img  = '0;
    endtask

    task automatic apply_cfg(input logic [2:0] idx, input logic [31:0] val);
        int i;
        if (idx < CFG_IO_MASK)
        begin
            size_reg[idx - CFG_BAR0_SIZE] = val;
        end
        else if (idx == CFG_IO_MASK)
        begin
            // A new mask reshapes the type bits of every BAR already stored.
            io_sel = val[5:0];
            for (i = 0; i < NUM_BARS; i++)
            begin
                bar_img[i] = with_type_bits(i, bar_img[i]);
            end
        end
        else if (idx == CFG_VDID)
        begin
            id_word = val;
        end
    endtask

    // One byte of the header image; unimplemented bytes read as zero.
    function automatic logic [7:0] hdr_byte(input int unsigned a);
        int unsigned n;
        logic [7:0]  b;
        b = 8'h00;
        if (a < 4)
        begin
            b = id_word[8*a +: 8];
        end
        else if (a == OFS_COMMAND || a == OFS_COMMAND + 1)
        begin
            b = cmd_img[8*(a - OFS_COMMAND) +: 8];
        end
        else if (a == OFS_STATUS || a == OFS_STATUS + 1)
        begin
            b = stat_img[8*(a - OFS_STATUS) +: 8];
        end
        else if (a == OFS_CACHE)
        begin
            b = cls_img;
        end
        else if (a == OFS_LATENCY)
        begin
            b = lat_img;
        end
        else if (a >= OFS_BAR0 && a < OFS_BAR0 + 24)
        begin
            n = (a - OFS_BAR0) / 4;
            if (n < NUM_BARS)
            begin
                b = bar_img[n][8*(a % 4) +: 8];
            end
        end
        else if (a >= OFS_ROM && a < OFS_ROM + 4)
        begin
            b = rom_img[8*(a % 4) +: 8];
        end
        else if (a == OFS_IRQ_LINE)
        begin
            b = irq_img;
        end
        return b;
    endfunction

    // Write into the image copy; returns the completion status.
    function automatic logic [1:0] apply_write(input logic [7:0] ofs, input logic [2:0] sz,
                                               input logic [31:0] d);
        int unsigned n;
        logic [1:0]  st;
        st = ST_OK;
        if (sz == ACC_BYTE)
        begin
            if (ofs == OFS_IRQ_LINE)
                irq_img = d[7:0];
            else if (ofs == OFS_CACHE)
                cls_img = d[7:0];
            else if (ofs == OFS_LATENCY)
                lat_img = d[7:0];
            else
                st = ST_READ_ONLY;
        end
        else if (sz == ACC_HALF)
        begin
            if (ofs == OFS_COMMAND)
                cmd_img = d[15:0];
            else if (ofs == OFS_STATUS)
                stat_img = d[15:0];
            else if (ofs == OFS_CACHE)
            begin
                cls_img = d[7:0];
                lat_img = d[15:8];
            end
            else
                st = ST_READ_ONLY;
        end
        else
        begin
            // Dword writes to anything but a BAR, the ROM base or the
            // command word are dropped without an error.
            if (ofs >= OFS_BAR0 && ofs < OFS_BAR0 + 24 && ofs[1:0] == 2'b00)
            begin
                n = (ofs - OFS_BAR0) / 4;
                if (n < NUM_BARS)
                begin
                    if (d == BAR_ALL_ONES)
                        bar_img[n] = ~(size_reg[n] - 32'd1) | (io_sel[n] ? IO_TYPE_BITS : 32'h0);
                    else
                        bar_img[n] = with_type_bits(n, d);
                end
            end
            else if (ofs == OFS_ROM)
            begin
                rom_img = (d == ROM_PROBE) ? BAR_ALL_ONES : d;
            end
            else if (ofs == OFS_COMMAND)
            begin
                cmd_img = d[15:0];
            end
        end
        return st;
    endfunction

    function automatic rsp_t predict_access(input req_t r);
        rsp_t o;
        int   k;
        o = '0;
        if (r.offset >= HEADER_BYTES)
        begin
            o.status = ST_BEYOND;
        end
        else if (r.access_size != ACC_BYTE && r.access_size != ACC_HALF &&
                 r.access_size != ACC_DWORD)
        begin
            o.status = ST_BAD_SIZE;
        end
        else if (r.req_type == REQ_WRITE)
        begin
            o.status = apply_write(r.offset, r.access_size, r.write_data);
        end
        else
        begin
            // Bytes are gathered one at a time, so unaligned reads and reads
            // running past the header come out naturally.
            for (k = 0; k < r.access_size; k++)
            begin
                o.read_data[8*k +: 8] = hdr_byte(r.offset + k);
            end
            o.status = ST_OK;
        end
        return o;
    endfunction

    // Track configuration writes, predict on request transactions and
    // compare on completion transactions.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        due_t head;
        due_t fresh;
        if (!rst_n)
        begin
            reset_image();
            owed_completions.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                apply_cfg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                fresh.req = in_data;
                fresh.rsp = predict_access(in_data);
                owed_completions.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (owed_completions.size() == 0)
                begin
                    report_fail($sformatf("completion with no request outstanding: data %h status %0d",
                                          out_data.read_data, out_data.status));
                end
                else
                begin
                    head = owed_completions.pop_front();
                    if (out_data.read_data !== head.rsp.read_data)
                    begin
                        report_fail($sformatf("read_data %h, expected %h (wr %0b ofs %h size %0d data %h)",
                                              out_data.read_data, head.rsp.read_data,
                                              head.req.req_type, head.req.offset,
                                              head.req.access_size, head.req.write_data));
                    end
                    if (out_data.status !== head.rsp.status)
                    begin
                        report_fail($sformatf("status %0d, expected %0d (wr %0b ofs %h size %0d data %h)",
                                              out_data.status, head.rsp.status,
                                              head.req.req_type, head.req.offset,
                                              head.req.access_size, head.req.write_data));
                    end
                end
            end
            pending = owed_completions.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Testbench for the PCI configuration header block. A directed pass covers
// every register, the size probes, read-only and error cases; then random
// phases under different BAR sizes, I/O masks and IDs issue mostly register
// accesses and BAR probe sequences, with bursty requests and a stalling
// completion side. A checker beside the block predicts and compares.
// ============================================================================
module tb_top;
    import pchr_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 215;
    localparam int SETTLE      = 8;
    localparam int DRAIN_TAIL  = 12;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    req_t        in_data;
    logic        out_valid;
    logic        out_ready;
    rsp_t        out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int error_count;
    int pending;
    bit hold_req;
    int burst_left;
    int quiet_cycles;

    pci_config_header_regs dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pchr_access_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog: too long without any transaction ends the run.
    initial quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Completion side: changing stall modes, plus a long hold-off on request.
    initial
    begin : receiver
        int hold_left;
        int mode;
        int mode_left;
        int tick;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 9) > 3);
                    2:       out_ready <= ((tick % 5) < 2);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    function automatic req_t mk_req(input logic rw, input logic [7:0] ofs,
                                    input logic [2:0] sz, input logic [31:0] d);
        req_t r;
        r.req_type    = rw;
        r.offset      = ofs;
        r.access_size = sz;
        r.write_data  = d;
        return r;
    endfunction

    // Offer one transaction and wait for it; bursts end in a random gap.
    task automatic send_req(input req_t r);
        in_data  <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 30)) @(negedge clk);
            else
                repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(0, 12);
        end
    endtask

    task automatic idle_input();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Configuration writes only once the block has gone quiet.
    task automatic apply_settings(input logic [5:0][31:0] sizes, input logic [5:0] mask,
                                  input logic [31:0] id);
        int i;
        idle_input();
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        for (i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_BAR0_SIZE + i[2:0];
            cfg_data  <= sizes[i];
            @(negedge clk);
        end
        cfg_index <= CFG_IO_MASK;
        cfg_data  <= {26'd0, mask};
        @(negedge clk);
        cfg_index <= CFG_VDID;
        cfg_data  <= id;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Phase 0 takes the low extremes, phase 1 the high ones, later ones random.
    task automatic random_settings(input int phase);
        logic [5:0][31:0] sizes;
        logic [5:0]       mask;
        logic [31:0]      id;
        int               i;
        for (i = 0; i < 6; i++)
        begin
            if (phase == 0)
                sizes[i] = 32'h0;
            else if (phase == 1)
                sizes[i] = 32'h8000_0000;
            else if ($urandom_range(0, 9) == 0)
                sizes[i] = 32'h0;
            else
                sizes[i] = 32'h1 << $urandom_range(0, 31);
        end
        mask = (phase == 0) ? 6'h00 : (phase == 1) ? 6'h3F : $urandom_range(0, 63);
        id   = (phase == 0) ? 32'h0 : (phase == 1) ? 32'hFFFF_FFFF : $urandom;
        apply_settings(sizes, mask, id);
    endtask

    function automatic logic [7:0] hot_offset();
        logic [7:0] o;
        case ($urandom_range(0, 15))
            0:       o = 8'h00;
            1:       o = 8'h02;
            2:       o = OFS_COMMAND;
            3:       o = OFS_STATUS;
            4:       o = OFS_CACHE;
            5:       o = OFS_LATENCY;
            6:       o = OFS_BAR0;
            7:       o = OFS_BAR0 + 8'h04;
            8:       o = OFS_BAR0 + 8'h08;
            9:       o = OFS_BAR0 + 8'h0C;
            10:      o = OFS_BAR0 + 8'h10;
            11:      o = OFS_BAR0 + 8'h14;
            12:      o = OFS_BAR0 + 8'h18;
            13:      o = OFS_ROM;
            14:      o = OFS_IRQ_LINE;
            default: o = 8'h3D;
        endcase
        return o;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   pick;
        r.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.offset = hot_offset();
        else if (pick < 90)
            r.offset = $urandom_range(0, 63);
        else
            r.offset = $urandom_range(64, 255);
        pick = $urandom_range(0, 99);
        if (pick < 25)
            r.access_size = ACC_BYTE;
        else if (pick < 50)
            r.access_size = ACC_HALF;
        else if (pick < 88)
            r.access_size = ACC_DWORD;
        else
            r.access_size = $urandom_range(0, 7);
        pick = $urandom_range(0, 99);
        if (pick < 15)
            r.write_data = BAR_ALL_ONES;
        else if (pick < 22)
            r.write_data = ROM_PROBE;
        else
            r.write_data = $urandom;
        return r;
    endfunction

    // Size probe: all ones, read back, then a new base; ROM now and then.
    task automatic run_probe();
        int         n;
        logic [7:0] ofs;
        n = $urandom_range(0, 6);
        if (n == 6)
        begin
            ofs = OFS_ROM;
            send_req(mk_req(REQ_WRITE, ofs, ACC_DWORD, ROM_PROBE));
        end
        else
        begin
            ofs = OFS_BAR0 + n * 4;
            send_req(mk_req(REQ_WRITE, ofs, ACC_DWORD, BAR_ALL_ONES));
        end
        send_req(mk_req(REQ_READ, ofs, ACC_DWORD, $urandom));
        send_req(mk_req(REQ_WRITE, ofs, ACC_DWORD, $urandom));
    endtask

    task automatic run_directed();
        // Identity, command and status.
        send_req(mk_req(REQ_READ,  8'h00,       ACC_DWORD, 32'h0));
        send_req(mk_req(REQ_READ,  8'h02,       ACC_HALF,  32'h0));
        send_req(mk_req(REQ_WRITE, OFS_COMMAND, ACC_HALF,  32'h0000_FFFF));
        send_req(mk_req(REQ_WRITE, OFS_STATUS,  ACC_HALF,  32'hFFFF_A5A5));
        send_req(mk_req(REQ_WRITE, OFS_COMMAND, ACC_DWORD, 32'h5555_1234));
        send_req(mk_req(REQ_READ,  OFS_COMMAND, ACC_DWORD, 32'h0));
        // Cache line, latency timer and interrupt line.
        send_req(mk_req(REQ_WRITE, OFS_CACHE,    ACC_BYTE, 32'hFFFF_FF40));
        send_req(mk_req(REQ_WRITE, OFS_LATENCY,  ACC_BYTE, 32'h0000_00FF));
        send_req(mk_req(REQ_WRITE, OFS_CACHE,    ACC_HALF, 32'h0000_1234));
        send_req(mk_req(REQ_WRITE, OFS_IRQ_LINE, ACC_BYTE, 32'h0000_000B));
        // Narrow writes to read-only bytes, ignored dword write.
        send_req(mk_req(REQ_WRITE, 8'h00, ACC_BYTE,  32'hFFFF_FFFF));
        send_req(mk_req(REQ_WRITE, 8'h02, ACC_HALF,  32'hFFFF_FFFF));
        send_req(mk_req(REQ_WRITE, 8'h00, ACC_DWORD, 32'hFFFF_FFFF));
        // BAR size probes on memory and I/O BARs, plain base writes.
        send_req(mk_req(REQ_WRITE, OFS_BAR0,         ACC_DWORD, BAR_ALL_ONES));
        send_req(mk_req(REQ_READ,  OFS_BAR0,         ACC_DWORD, 32'h0));
        send_req(mk_req(REQ_WRITE, OFS_BAR0 + 8'h04, ACC_DWORD, BAR_ALL_ONES));
        send_req(mk_req(REQ_WRITE, OFS_BAR0 + 8'h0C, ACC_DWORD, BAR_ALL_ONES));
        send_req(mk_req(REQ_WRITE, OFS_BAR0 + 8'h10, ACC_DWORD, BAR_ALL_ONES));
        send_req(mk_req(REQ_WRITE, OFS_BAR0 + 8'h08, ACC_DWORD, 32'hDEAD_BEEF));
        send_req(mk_req(REQ_WRITE, OFS_BAR0 + 8'h14, ACC_DWORD, 32'hFFFF_FFF3));
        send_req(mk_req(REQ_READ,  OFS_BAR0 + 8'h03, ACC_DWORD, 32'h0));
        // ROM probe value, read across the end of the header.
        send_req(mk_req(REQ_WRITE, OFS_ROM, ACC_DWORD, ROM_PROBE));
        send_req(mk_req(REQ_READ,  8'h3E,   ACC_DWORD, 32'h0));
        // Beyond the header wins over a bad size; bad sizes.
        send_req(mk_req(REQ_WRITE, 8'hFF,   3'd7,      32'hFFFF_FFFF));
        send_req(mk_req(REQ_READ,  8'h40,   ACC_BYTE,  32'h0));
        send_req(mk_req(REQ_READ,  8'h00,   3'd0,      32'h0));
        send_req(mk_req(REQ_WRITE, OFS_ROM, 3'd3,      32'h1234_5678));
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        int               phase;
        int               done_items;
        bit               held;
        bit               paused;
        logic [5:0][31:0] sizes;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pass with a mix of memory and I/O BARs.
        sizes[0] = 32'h0000_1000;
        sizes[1] = 32'h0000_0100;
        sizes[2] = 32'h0;
        sizes[3] = 32'h8000_0000;
        sizes[4] = 32'h0000_0001;
        sizes[5] = 32'h0000_0010;
        apply_settings(sizes, 6'b010010, 32'h1234_ABCD);
        run_directed();

        for (phase = 0; phase < PHASES; phase++)
        begin
            random_settings(phase);
            done_items = 0;
            held       = 1'b0;
            paused     = 1'b0;
            while (done_items < PHASE_ITEMS)
            begin
                if (!held && done_items >= 60)
                begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                end
                if (!paused && done_items >= 130)
                begin
                    idle_input();
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 99) < 15)
                begin
                    run_probe();
                    done_items += 3;
                end
                else
                begin
                    send_req(random_req());
                    done_items++;
                end
            end
        end

        idle_input();
        wait_drained();
        repeat (DRAIN_TAIL) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
